### rtl/ipru_pkg.sv
package ipru_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_FACTOR = 64;

   localparam int SCALE_W  = 7;
   localparam int WIDTH_W  = 13;
   localparam int ADDR_W   = $clog2(MAX_WIDTH);
   localparam int RUN_W    = $clog2(MAX_FACTOR);
   localparam int PIXEL_W  = 24;
   localparam int PAD_W    = 2;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   typedef enum logic {
      OP_PUSH   = 1'b0,
      OP_REPLAY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      FAULT_NONE        = 2'd0,
      FAULT_PUSH_BUSY   = 2'd1,
      FAULT_REPLAY_IDLE = 2'd2
   } fault_type;

   typedef enum logic {
      REG_SCALE_FACTOR = 1'b0,
      REG_SOURCE_WIDTH = 1'b1
   } reg_index_type;

endpackage

### rtl/ipru_ram.sv
module ipru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/integer_pixel_replication_upscaler.sv
// channel | direction | fields                                        | handshake
// req     | in        | op, blue_in, green_in, red_in                 | req_valid / req_stall
// rsp     | out       | blue/green/red_out, line_end, pad_count,      | rsp_valid / rsp_stall
//         |           | run_last, fault                               |
// csr     | in/out    | scale_factor (0x0), source_width (0x4)        | apb write, pready high
// each transaction yields factor result pixels, one per cycle while not stalled; a fault yields one
// the next request is taken in the cycle the last result of the current one leaves,
// so an item occupies the result register until its last copy leaves (factor 1 to 64)
// replayed pixels come from the row buffer, read at accept and shown from its output register
// reset is synchronous; the row buffer is not cleared and holds garbage until pushed
// a stalled result holds its payload and keeps the request side stalled
module integer_pixel_replication_upscaler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [7:0]                        req_blue_in,
   input  logic [7:0]                        req_green_in,
   input  logic [7:0]                        req_red_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_blue_out,
   output logic [7:0]                        rsp_green_out,
   output logic [7:0]                        rsp_red_out,
   output logic                              rsp_line_end,
   output logic [ipru_pkg::PAD_W-1:0]        rsp_pad_count,
   output logic                              rsp_run_last,
   output logic [1:0]                        rsp_fault,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ipru_pkg::CSR_AW-1:0]       paddr,
   input  logic [ipru_pkg::CSR_DW-1:0]       pwdata,
   output logic [ipru_pkg::CSR_DW-1:0]       prdata,
   output logic                              pready
);

   logic [ipru_pkg::SCALE_W-1:0] scale_ff;
   logic [ipru_pkg::WIDTH_W-1:0] width_ff;

   logic [ipru_pkg::ADDR_W-1:0]  col_ff, col_in;
   logic [ipru_pkg::RUN_W-1:0]   repeat_ff, repeat_in;
   logic                         phase_ff, phase_in;

   logic                         job_valid_ff;
   logic [ipru_pkg::RUN_W-1:0]   job_k_ff;
   logic [ipru_pkg::RUN_W-1:0]   job_fm1_ff;
   logic                         job_ram_ff;
   logic [ipru_pkg::PIXEL_W-1:0] job_pix_ff;
   logic                         job_ends_ff;
   logic [ipru_pkg::PAD_W-1:0]   job_pad_ff;
   ipru_pkg::fault_type          job_fault_ff;

   logic                         csr_write;
   ipru_pkg::reg_index_type      csr_index;
   logic [ipru_pkg::SCALE_W-1:0] factor;
   logic [ipru_pkg::RUN_W-1:0]   factor_m1;
   logic [ipru_pkg::WIDTH_W-1:0] width_eff;
   logic [3:0]                   pad_prod;
   logic [ipru_pkg::PAD_W-1:0]   pad;
   logic                         ends;
   logic                         req_fire;
   logic                         is_push;
   ipru_pkg::fault_type          fault;
   logic                         job_last;
   logic                         job_done;
   logic                         ram_we;
   logic                         ram_re;
   logic [ipru_pkg::PIXEL_W-1:0] ram_rdata;
   logic [ipru_pkg::PIXEL_W-1:0] pixel;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = ipru_pkg::reg_index_type'(paddr[2]);

   always_comb begin
      case (csr_index)
         ipru_pkg::REG_SCALE_FACTOR:
            prdata = ipru_pkg::CSR_DW'(scale_ff);
         ipru_pkg::REG_SOURCE_WIDTH:
            prdata = ipru_pkg::CSR_DW'(width_ff);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ipru_pkg::SCALE_W'(1);
         width_ff <= ipru_pkg::WIDTH_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            ipru_pkg::REG_SCALE_FACTOR: scale_ff <= pwdata[ipru_pkg::SCALE_W-1:0];
            ipru_pkg::REG_SOURCE_WIDTH: width_ff <= pwdata[ipru_pkg::WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the registers to their usable ranges
   always_comb begin
      if (scale_ff == '0) begin
         factor = ipru_pkg::SCALE_W'(1);
      end else if (scale_ff > ipru_pkg::SCALE_W'(ipru_pkg::MAX_FACTOR)) begin
         factor = ipru_pkg::SCALE_W'(ipru_pkg::MAX_FACTOR);
      end else begin
         factor = scale_ff;
      end
      if (width_ff == '0) begin
         width_eff = ipru_pkg::WIDTH_W'(1);
      end else if (width_ff > ipru_pkg::WIDTH_W'(ipru_pkg::MAX_WIDTH)) begin
         width_eff = ipru_pkg::WIDTH_W'(ipru_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
   end

   assign factor_m1 = ipru_pkg::RUN_W'(factor - ipru_pkg::SCALE_W'(1));
   // only the low two bits of width and factor matter modulo four
   assign pad_prod  = {2'b00, width_eff[1:0]} * {2'b00, factor[1:0]};
   assign pad       = pad_prod[ipru_pkg::PAD_W-1:0];
   assign ends      = (ipru_pkg::WIDTH_W'(col_ff) + ipru_pkg::WIDTH_W'(1)) >= width_eff;

   // result register drains one copy per cycle while the result is not stalled
   assign job_last  = (job_k_ff == job_fm1_ff);
   assign job_done  = job_valid_ff & job_last & ~rsp_stall;
   assign req_stall = job_valid_ff & ~job_done;
   assign req_fire  = req_valid & ~req_stall;
   assign is_push   = (ipru_pkg::op_type'(req_op) == ipru_pkg::OP_PUSH);

   always_comb begin
      if (is_push && phase_ff) begin
         fault = ipru_pkg::FAULT_PUSH_BUSY;
      end else if (!is_push && !phase_ff) begin
         fault = ipru_pkg::FAULT_REPLAY_IDLE;
      end else begin
         fault = ipru_pkg::FAULT_NONE;
      end
   end

   assign ram_we = req_fire & is_push & (fault == ipru_pkg::FAULT_NONE);
   assign ram_re = req_fire & ~is_push & (fault == ipru_pkg::FAULT_NONE);

   always_comb begin
      col_in    = col_ff;
      repeat_in = repeat_ff;
      phase_in  = phase_ff;
      if (ram_we || ram_re) begin
         if (ends) begin
            col_in = '0;
         end else begin
            col_in = col_ff + ipru_pkg::ADDR_W'(1);
         end
      end
      if (ram_we && ends && factor_m1 != '0) begin
         phase_in  = 1'b1;
         repeat_in = factor_m1;
      end
      if (ram_re && ends) begin
         if (repeat_ff != '0) begin
            repeat_in = repeat_ff - ipru_pkg::RUN_W'(1);
         end
         phase_in = (repeat_ff > ipru_pkg::RUN_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         repeat_ff    <= '0;
         phase_ff     <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         repeat_ff <= repeat_in;
         phase_ff  <= phase_in;
         if (req_fire) begin
            job_valid_ff <= 1'b1;
         end else if (job_done) begin
            job_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         job_k_ff     <= '0;
         job_fault_ff <= fault;
         if (fault == ipru_pkg::FAULT_NONE) begin
            job_fm1_ff  <= factor_m1;
            job_ram_ff  <= ~is_push;
            job_pix_ff  <= {req_red_in, req_green_in, req_blue_in};
            job_ends_ff <= ends;
            job_pad_ff  <= pad;
         end else begin
            job_fm1_ff  <= '0;
            job_ram_ff  <= 1'b0;
            job_pix_ff  <= '0;
            job_ends_ff <= 1'b0;
            job_pad_ff  <= '0;
         end
      end else if (job_valid_ff && !rsp_stall && !job_last) begin
         job_k_ff <= job_k_ff + ipru_pkg::RUN_W'(1);
      end
   end

   ipru_ram #(
      .WIDTH (ipru_pkg::PIXEL_W),
      .DEPTH (ipru_pkg::MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (col_ff),
      .wdata ({req_red_in, req_green_in, req_blue_in}),
      .re    (ram_re),
      .raddr (col_ff),
      .rdata (ram_rdata)
   );

   assign pixel         = job_ram_ff ? ram_rdata : job_pix_ff;
   assign rsp_valid     = job_valid_ff;
   assign rsp_blue_out  = pixel[7:0];
   assign rsp_green_out = pixel[15:8];
   assign rsp_red_out   = pixel[23:16];
   assign rsp_line_end  = job_last & job_ends_ff;
   assign rsp_pad_count = (job_last & job_ends_ff) ? job_pad_ff : '0;
   assign rsp_run_last  = job_last;
   assign rsp_fault     = job_fault_ff;

endmodule

### rtl/ipru_checker.sv
module ipru_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [7:0]                 rsp_blue_out,
   input logic [7:0]                 rsp_green_out,
   input logic [7:0]                 rsp_red_out,
   input logic                       rsp_line_end,
   input logic [ipru_pkg::PAD_W-1:0] rsp_pad_count,
   input logic                       rsp_run_last,
   input logic [1:0]                 rsp_fault
);

   // a fault transaction is a single blank result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault != 2'(ipru_pkg::FAULT_NONE)
         |-> rsp_run_last && !rsp_line_end && rsp_pad_count == '0
             && rsp_blue_out == '0 && rsp_green_out == '0 && rsp_red_out == '0)
      else $error("fault result not blank");

   // padding only at a scanline end, and a scanline ends on the last copy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pad_count != '0 || rsp_line_end) |-> rsp_line_end && rsp_run_last)
      else $error("line end or padding off the last copy");

   // copies of one pixel stay identical until the run ends
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_last
         |=> rsp_valid && $stable(rsp_blue_out) && $stable(rsp_green_out)
             && $stable(rsp_red_out) && rsp_fault == 2'(ipru_pkg::FAULT_NONE))
      else $error("run broken or pixel changed mid-run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_blue_out)
         && $stable(rsp_run_last) && $stable(rsp_fault))
      else $error("stalled result changed");

endmodule

bind integer_pixel_replication_upscaler ipru_checker u_ipru_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_green_out (rsp_green_out),
   .rsp_red_out   (rsp_red_out),
   .rsp_line_end  (rsp_line_end),
   .rsp_pad_count (rsp_pad_count),
   .rsp_run_last  (rsp_run_last),
   .rsp_fault     (rsp_fault)
);
